/* src/jos_pkg.sv */
// ----------------------------------------------------------------------------
// jos_pkg
// Shared types, character codes and defaults for the JSON object splitter
// ----------------------------------------------------------------------------
package jos_pkg;

    localparam int JOS_MAX_DEPTH = 255;
    localparam int JOS_LEN_BITS  = 12;
    localparam int CFG_BITS      = 12;
    localparam logic [CFG_BITS-1:0] CFG_MAX_LEN_RESET = 12'd255;

    // register indexes
    localparam logic REG_MAX_OBJECT_LEN = 1'b0;

    // characters
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;

    // result status codes
    localparam logic [1:0] ST_OBJ_BYTE  = 2'd0;
    localparam logic [1:0] ST_OBJ_END   = 2'd1;
    localparam logic [1:0] ST_ARRAY_END = 2'd2;
    localparam logic [1:0] ST_UNTERM    = 2'd3;

    typedef enum logic [1:0] {
        MODE_SEEK = 2'd0,
        MODE_OBJ  = 2'd1,
        MODE_DONE = 2'd2
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       restart;
    } item_t;

    typedef struct packed {
        logic       truncated;
        logic [1:0] status;
        logic       char_valid;
        logic [7:0] char_out;
    } result_t;

endpackage

/* src/jos_cfg_regs.sv */
// ----------------------------------------------------------------------------
// jos_cfg_regs
// APB register file holding the object length limit
// ----------------------------------------------------------------------------
module jos_cfg_regs (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    output logic [jos_pkg::CFG_BITS-1:0] max_len
);
    import jos_pkg::*;

    logic [CFG_BITS-1:0] max_len_reg;
    logic [CFG_BITS-1:0] max_len_next;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        max_len_next = max_len_reg;
        if (wr_en && (paddr[2] == REG_MAX_OBJECT_LEN)) begin
            max_len_next = pwdata[CFG_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= CFG_MAX_LEN_RESET;
        end else begin
            max_len_reg <= max_len_next;
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_MAX_OBJECT_LEN) begin
            prdata = {{(32-CFG_BITS){1'b0}}, max_len_reg};
        end
    end

    assign max_len = max_len_reg;

endmodule

/* src/jos_framer.sv */
// ----------------------------------------------------------------------------
// jos_framer
// Scan state and per-byte framing logic: depth, string and escape tracking
// ----------------------------------------------------------------------------
module jos_framer #(
    parameter int MAX_DEPTH = jos_pkg::JOS_MAX_DEPTH,
    parameter int LEN_BITS  = jos_pkg::JOS_LEN_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  jos_pkg::item_t               item,
    input  logic [jos_pkg::CFG_BITS-1:0] max_len,
    output logic                         has_result,
    output jos_pkg::result_t             result
);
    import jos_pkg::*;

    localparam int DEPTH_BITS = $clog2(MAX_DEPTH + 1);
    localparam int CMP_BITS   = (LEN_BITS > CFG_BITS) ? LEN_BITS : CFG_BITS;
    localparam logic [CMP_BITS-1:0] LEN_MASK = CMP_BITS'((1 << LEN_BITS) - 1);
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = DEPTH_BITS'(MAX_DEPTH);

    scan_mode_t            mode_reg, mode_next;
    logic [DEPTH_BITS-1:0] depth_reg, depth_next;
    logic                  str_reg, str_next;
    logic                  esc_reg, esc_next;
    logic [LEN_BITS-1:0]   kept_reg, kept_next;

    scan_mode_t            mode_eff;
    logic                  in_obj;
    logic                  process;
    logic                  array_end;
    logic [7:0]            ch;
    logic [DEPTH_BITS-1:0] depth_base, depth_upd;
    logic                  str_base, str_upd;
    logic                  esc_base, esc_upd;
    logic [LEN_BITS-1:0]   kept_base;
    logic                  ended;
    logic [CMP_BITS-1:0]   cfg_ext, limit;
    logic                  keep;

    assign ch       = item.char_in;
    assign mode_eff = item.restart ? MODE_SEEK : mode_reg;
    assign in_obj   = (mode_eff == MODE_OBJ);
    assign process  = in_obj || ((mode_eff == MODE_SEEK) && (ch == CH_LBRACE));
    assign array_end = (mode_eff == MODE_SEEK) && ((ch == CH_NUL) || (ch == CH_RBRACKET));

    // a fresh object starts from cleared tracking state
    assign depth_base = in_obj ? depth_reg : '0;
    assign str_base   = in_obj ? str_reg : 1'b0;
    assign esc_base   = in_obj ? esc_reg : 1'b0;
    assign kept_base  = in_obj ? kept_reg : '0;

    always_comb begin
        depth_upd = depth_base;
        str_upd   = str_base;
        esc_upd   = esc_base;
        ended     = 1'b0;
        if (str_base) begin
            if (esc_base) begin
                esc_upd = 1'b0;
            end else if (ch == CH_BSLASH) begin
                esc_upd = 1'b1;
            end else if (ch == CH_QUOTE) begin
                str_upd = 1'b0;
            end
        end else if (ch == CH_QUOTE) begin
            str_upd = 1'b1;
        end else if (ch == CH_LBRACE) begin
            if (depth_base < DEPTH_MAX) begin
                depth_upd = depth_base + DEPTH_BITS'(1);
            end
        end else if (ch == CH_RBRACE) begin
            if (depth_base != '0) begin
                depth_upd = depth_base - DEPTH_BITS'(1);
            end
            ended = (depth_upd == '0);
        end
    end

    assign cfg_ext = CMP_BITS'(max_len);
    assign limit   = (cfg_ext > LEN_MASK) ? LEN_MASK : cfg_ext;
    assign keep    = CMP_BITS'(kept_base) < limit;

    // next state
    always_comb begin
        mode_next  = mode_reg;
        depth_next = depth_reg;
        str_next   = str_reg;
        esc_next   = esc_reg;
        kept_next  = kept_reg;
        if (item.restart) begin
            mode_next  = MODE_SEEK;
            depth_next = '0;
            str_next   = 1'b0;
            esc_next   = 1'b0;
            kept_next  = '0;
        end
        if (array_end) begin
            mode_next = MODE_DONE;
        end else if (process) begin
            if (ch == CH_NUL) begin
                mode_next = MODE_DONE;
            end else if (ended) begin
                mode_next  = MODE_SEEK;
                depth_next = '0;
                str_next   = 1'b0;
                esc_next   = 1'b0;
                kept_next  = '0;
            end else begin
                mode_next  = MODE_OBJ;
                depth_next = depth_upd;
                str_next   = str_upd;
                esc_next   = esc_upd;
                kept_next  = keep ? (kept_base + LEN_BITS'(1)) : kept_base;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_SEEK;
            depth_reg <= '0;
            str_reg   <= 1'b0;
            esc_reg   <= 1'b0;
            kept_reg  <= '0;
        end else if (step) begin
            mode_reg  <= mode_next;
            depth_reg <= depth_next;
            str_reg   <= str_next;
            esc_reg   <= esc_next;
            kept_reg  <= kept_next;
        end
    end

    // outputs
    always_comb begin
        has_result        = 1'b0;
        result.char_out   = 8'd0;
        result.char_valid = 1'b0;
        result.status     = ST_OBJ_BYTE;
        result.truncated  = 1'b0;
        if (array_end) begin
            has_result    = 1'b1;
            result.status = ST_ARRAY_END;
        end else if (process) begin
            has_result = 1'b1;
            if (ch == CH_NUL) begin
                result.status = ST_UNTERM;
            end else begin
                result.char_out   = keep ? ch : 8'd0;
                result.char_valid = keep;
                if (ended) begin
                    result.status    = ST_OBJ_END;
                    result.truncated = !keep;
                end
            end
        end
    end

endmodule

/* src/json_object_splitter.sv */
// ----------------------------------------------------------------------------
// json_object_splitter
// Splits a JSON array body into objects, one text byte per request
// ----------------------------------------------------------------------------
// Takes one text byte per clock cycle while the output side is not stalled,
// and returns at most one result per byte through the result register.
// Bytes pass through an input register, the combinational framing update of
// the scan state (depth, string, escape and kept-byte count), and a result
// register; the feedback loop of that scan state sets the rate of one byte
// per cycle. Bytes outside an object, other than the NUL or ']' that ends
// the array, and all bytes after the array end until a restart, produce no result.
module json_object_splitter #(
    parameter int MAX_DEPTH = jos_pkg::JOS_MAX_DEPTH,
    parameter int LEN_BITS  = jos_pkg::JOS_LEN_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic [0:0]  s_tuser,   // [0] restart
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] char_out
    output logic [3:0]  m_tuser,   // [0] char_valid, [2:1] status, [3] truncated
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import jos_pkg::*;

    logic                in_valid_reg, in_valid_next;
    item_t               in_item_reg;
    logic                out_valid_reg, out_valid_next;
    result_t             out_res_reg;
    logic                step;
    logic                has_result;
    result_t             result;
    logic [CFG_BITS-1:0] max_len;

    jos_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .max_len (max_len)
    );

    jos_framer #(
        .MAX_DEPTH (MAX_DEPTH),
        .LEN_BITS  (LEN_BITS)
    ) u_framer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .item       (in_item_reg),
        .max_len    (max_len),
        .has_result (has_result),
        .result     (result)
    );

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = has_result;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.char_in <= s_tdata;
            in_item_reg.restart <= s_tuser[0];
        end
        if (step) begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.char_out;
    assign m_tuser  = {out_res_reg.truncated, out_res_reg.status, out_res_reg.char_valid};

endmodule
